FILE: hw/rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CAP_W  = 25;
  localparam int unsigned LEN_W  = 30;
  localparam int unsigned HDR_W  = 32;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned KIND_W = 2;

  // configuration port
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(65536);

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DROPPED = 2'd2
  } event_kind_t;

  // one result from the parser to the output register
  typedef struct packed {
    logic              valid;
    event_kind_t       kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
    logic [LEN_W-1:0]  length;
  } lpd_result_t;

endpackage

FILE: hw/rtl/lpd_ifs.sv
// ----------------------------------------------------------------------------
// lpd_ifs
// Valid/ready channels for the raw byte stream and the deframed results.
// ----------------------------------------------------------------------------

// raw byte stream
interface lpd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [lpd_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// deframed results
interface lpd_event_if;
  logic                       valid;
  logic                       ready;
  logic [lpd_pkg::KIND_W-1:0] event_kind;
  logic [lpd_pkg::BYTE_W-1:0] payload_byte;
  logic                       frame_last;
  logic [lpd_pkg::LEN_W-1:0]  frame_length;

  modport source (output valid, output event_kind, output payload_byte,
                  output frame_last, output frame_length, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input frame_last, input frame_length, output ready);
endinterface

FILE: hw/rtl/lpd_parser.sv
// ----------------------------------------------------------------------------
// lpd_parser
// Header gathering, payload counting and capacity check; one byte per take.
// ----------------------------------------------------------------------------
module lpd_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [lpd_pkg::BYTE_W-1:0]  data_byte,
  input  logic [lpd_pkg::CAP_W-1:0]   capacity,
  output lpd_pkg::lpd_result_t        result
);

  logic [lpd_pkg::HDR_W-1:0] header_value, header_value_next;
  logic [lpd_pkg::CNT_W-1:0] header_count, header_count_next;
  logic [lpd_pkg::CNT_W-1:0] header_size, header_size_next;
  logic [lpd_pkg::LEN_W-1:0] payload_left, payload_left_next;
  logic                      skipping, skipping_next;

  logic [lpd_pkg::LEN_W-1:0] left_dec;
  logic [lpd_pkg::HDR_W-1:0] hv_new;
  logic [lpd_pkg::CNT_W-1:0] cnt_new;
  logic [lpd_pkg::CNT_W-1:0] size_new;
  logic [lpd_pkg::LEN_W-1:0] len_new;
  logic [lpd_pkg::LEN_W:0]   frame_total;

  assign left_dec = payload_left - lpd_pkg::LEN_W'(1);
  assign len_new  = hv_new[lpd_pkg::HDR_W-1:2];
  assign frame_total = {1'b0, len_new} + (lpd_pkg::LEN_W+1)'(size_new);

  // merge the incoming byte into the header
  always_comb begin
    hv_new   = header_value;
    cnt_new  = header_count + lpd_pkg::CNT_W'(1);
    size_new = header_size;
    case (header_count[1:0])
      2'd0: begin
        hv_new   = {24'd0, data_byte};
        size_new = {1'b0, data_byte[1:0]} + lpd_pkg::CNT_W'(1);
      end
      2'd1: hv_new = header_value | {16'd0, data_byte, 8'd0};
      2'd2: hv_new = header_value | {8'd0, data_byte, 16'd0};
      default: hv_new = header_value | {data_byte, 24'd0};
    endcase
  end

  // next state and result
  always_comb begin
    header_value_next = header_value;
    header_count_next = header_count;
    header_size_next  = header_size;
    payload_left_next = payload_left;
    skipping_next     = skipping;
    result            = '0;
    result.kind       = lpd_pkg::KIND_PAYLOAD;

    if (payload_left != '0) begin
      payload_left_next = left_dec;
      if (skipping) begin
        if (left_dec == '0) begin
          skipping_next = 1'b0;
        end
      end else begin
        result.valid        = 1'b1;
        result.kind         = lpd_pkg::KIND_PAYLOAD;
        result.payload_byte = data_byte;
        result.last         = (left_dec == '0);
        result.length       = header_value[lpd_pkg::HDR_W-1:2];
      end
    end else begin
      header_value_next = hv_new;
      header_size_next  = size_new;
      if (cnt_new < size_new) begin
        header_count_next = cnt_new;
      end else begin
        header_count_next = '0;
        if (frame_total > (lpd_pkg::LEN_W+1)'(capacity)) begin
          // oversized: report once, then skip the payload
          payload_left_next = len_new;
          skipping_next     = (len_new != '0);
          result.valid      = 1'b1;
          result.kind       = lpd_pkg::KIND_DROPPED;
          result.last       = 1'b1;
          result.length     = len_new;
        end else if (len_new == '0) begin
          result.valid = 1'b1;
          result.kind  = lpd_pkg::KIND_EMPTY;
          result.last  = 1'b1;
        end else begin
          payload_left_next = len_new;
          skipping_next     = 1'b0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= '0;
      header_count <= '0;
      header_size  <= '0;
      payload_left <= '0;
      skipping     <= 1'b0;
    end else if (take) begin
      header_value <= header_value_next;
      header_count <= header_count_next;
      header_size  <= header_size_next;
      payload_left <= payload_left_next;
      skipping     <= skipping_next;
    end
  end

  // skip mode only while payload remains
  a_skip_has_left: assert property (@(posedge clk) disable iff (rst)
    skipping |-> (payload_left != '0))
    else $error("skipping with no payload left");

  // no header in progress while counting payload
  a_payload_no_hdr: assert property (@(posedge clk) disable iff (rst)
    (payload_left != '0) |-> (header_count == '0))
    else $error("header count nonzero during payload");

  // partial header is shorter than its announced size
  a_hdr_partial: assert property (@(posedge clk) disable iff (rst)
    (header_count != '0) |-> (header_count < header_size))
    else $error("header count reached header size");

endmodule

FILE: hw/rtl/length_prefix_deframer_top.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_top
// Splits a byte stream into frames with a 1-4 byte little-endian length header.
// ----------------------------------------------------------------------------
//  channel  dir   handshake        payload
//  rx       in    valid / ready    data_byte
//  evt      out   valid / ready    event_kind, payload_byte, frame_last,
//                                  frame_length
//  apb      in    psel / penable   paddr, pwdata, prdata (capacity register)
//
//  One byte per cycle unless evt stalls; its result shows in the next cycle.
//  The parser and a single output register set the rate: a byte is taken
//  whenever the output register is empty or being drained in the same cycle.
//  Reset (rst, synchronous) clears the parser state and sets capacity to 65536.
//  A stall on evt holds the result and blocks rx until it is taken.
// ----------------------------------------------------------------------------
module length_prefix_deframer_top (
  input  logic                        clk,
  input  logic                        rst,
  lpd_byte_if.sink                    rx,
  lpd_event_if.source                 evt,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpd_pkg::APB_AW-1:0]  paddr,
  input  logic [lpd_pkg::APB_DW-1:0]  pwdata,
  output logic [lpd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic [lpd_pkg::CAP_W-1:0] capacity;
  logic                      take;
  lpd_pkg::lpd_result_t      result;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lpd_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == lpd_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[lpd_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      lpd_pkg::REG_CAPACITY: prdata = {{(lpd_pkg::APB_DW-lpd_pkg::CAP_W){1'b0}}, capacity};
      default:               prdata = '0;
    endcase
  end

  // accept a request when the output slot is free or draining
  assign rx.ready = !evt.valid || evt.ready;
  assign take     = rx.valid && rx.ready;

  lpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (rx.data_byte),
    .capacity  (capacity),
    .result    (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (take) begin
      evt.valid <= result.valid;
    end else if (evt.ready) begin
      evt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      evt.event_kind   <= result.kind;
      evt.payload_byte <= result.payload_byte;
      evt.frame_last   <= result.last;
      evt.frame_length <= result.length;
    end
  end

  // non-payload results close their frame and carry no byte
  a_event_closes: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && (evt.event_kind != lpd_pkg::KIND_PAYLOAD))
      |-> (evt.frame_last && (evt.payload_byte == '0)))
    else $error("non-payload result without frame_last or with a byte");

  // empty frames announce zero length
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && (evt.event_kind == lpd_pkg::KIND_EMPTY)) |-> (evt.frame_length == '0))
    else $error("empty frame with nonzero length");

  // a pending result that is not taken blocks the input
  a_block_on_stall: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && !evt.ready) |-> !take)
    else $error("byte taken while a result is stalled");

  // output empty right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !evt.valid)
    else $error("result valid after reset");

endmodule
